// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; empty bodies when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising clock edge, off while reset is applied
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== hdl/ctam_pkg.sv =====
// ----------------------------------------------------------------------------
// ctam_pkg
// Types, constants and the threshold check functions of the cell alarm monitor.
// ----------------------------------------------------------------------------
package ctam_pkg;

  // Field widths
  localparam int IDX_W      = 5;
  localparam int VALUE_BITS = 16;
  localparam int TIME_W     = 32;
  localparam int THR_W      = 16;
  localparam int DUR_W      = 16;
  localparam int LIMIT_W    = 50;
  localparam int CFG_IDX_W  = 2;
  localparam int LVL_W      = 2;
  localparam int CMP_W      = (VALUE_BITS > THR_W) ? VALUE_BITS : THR_W;

  // Defaults
  localparam int NUM_CELLS_DEF = 32;
  localparam int MIN_START     = 5000;

  // Action levels
  localparam logic [LVL_W-1:0] LVL_NONE  = 2'd0;
  localparam logic [LVL_W-1:0] LVL_WARN  = 2'd1;
  localparam logic [LVL_W-1:0] LVL_ALARM = 2'd2;

  // Comparator modes
  typedef enum logic [1:0] {
    CMP_GT = 2'd0,
    CMP_GE = 2'd1,
    CMP_LT = 2'd2,
    CMP_LE = 2'd3
  } cmp_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALARM_HIGH = 2'd0,
    REG_WARN_HIGH  = 2'd1,
    REG_ALARM_LOW  = 2'd2,
    REG_WARN_LOW   = 2'd3
  } cfg_reg_t;

  // One limit register: duration, comparator, clear and set thresholds
  typedef struct packed {
    logic [DUR_W-1:0]        dur;
    cmp_t                    cmp;
    logic signed [THR_W-1:0] clr;
    logic signed [THR_W-1:0] set;
  } limit_t;

  typedef struct packed {
    limit_t alarm_hi;
    limit_t warn_hi;
    limit_t alarm_lo;
    limit_t warn_lo;
  } cfg_t;

  // Per-cell latch state of one side
  typedef struct packed {
    logic              sf;
    logic              cf;
    logic [TIME_W-1:0] ss;
    logic [TIME_W-1:0] cs;
  } side_state_t;

  typedef struct packed {
    side_state_t hi;
    side_state_t lo;
  } cell_state_t;

  typedef struct packed {
    side_state_t      st;
    logic             ev;
    logic [LVL_W-1:0] lvl;
  } side_res_t;

  // Running extremes
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] peak_value;
    logic [IDX_W-1:0]             peak_cell;
    logic signed [VALUE_BITS-1:0] trough_value;
    logic [IDX_W-1:0]             trough_cell;
  } trk_t;

  // Channel payloads
  typedef struct packed {
    logic [IDX_W-1:0]             cell_index;
    logic signed [VALUE_BITS-1:0] sample_value;
    logic [TIME_W-1:0]            now_seconds;
  } in_item_t;

  typedef struct packed {
    logic                         high_active;
    logic                         high_cleared;
    logic                         high_event;
    logic [LVL_W-1:0]             high_level;
    logic                         low_active;
    logic                         low_cleared;
    logic                         low_event;
    logic [LVL_W-1:0]             low_level;
    logic signed [VALUE_BITS-1:0] peak_value;
    logic [IDX_W-1:0]             peak_cell;
    logic signed [VALUE_BITS-1:0] trough_value;
    logic [IDX_W-1:0]             trough_cell;
  } out_item_t;

  // One set/clear pair check against a limit
  function automatic side_res_t pair_check(
    input limit_t                       lim,
    input logic signed [VALUE_BITS-1:0] v,
    input logic [TIME_W-1:0]            now,
    input logic [LVL_W-1:0]             level,
    input side_state_t                  st_in
  );
    side_res_t               r;
    logic signed [CMP_W-1:0] vx;
    logic signed [CMP_W-1:0] sx;
    logic signed [CMP_W-1:0] cx;
    logic                    sc;
    logic                    cc;
    logic [TIME_W-1:0]       dur;
    vx  = CMP_W'(v);
    sx  = CMP_W'(lim.set);
    cx  = CMP_W'(lim.clr);
    dur = TIME_W'(lim.dur);
    unique case (lim.cmp)
      CMP_GT: begin sc = vx >  sx; cc = vx <  cx; end
      CMP_GE: begin sc = vx >= sx; cc = vx <= cx; end
      CMP_LT: begin sc = vx <  sx; cc = vx >  cx; end
      CMP_LE: begin sc = vx <= sx; cc = vx >= cx; end
      default: begin sc = 1'b0; cc = 1'b0; end
    endcase
    r.st  = st_in;
    r.ev  = 1'b0;
    r.lvl = LVL_NONE;
    // set condition
    if (sc) begin
      if (!r.st.sf) begin
        if (TIME_W'(now - r.st.ss) > dur) begin
          r.st.sf = 1'b1;
          r.st.cf = 1'b0;
          r.st.ss = now;
          r.ev    = 1'b1;
          r.lvl   = level;
        end
      end else begin
        r.lvl = level;
      end
    end else begin
      r.st.ss = now;
    end
    // clear condition, sees the set latch as just updated
    if (cc) begin
      if (!r.st.cf) begin
        if (TIME_W'(now - r.st.cs) > dur) begin
          r.st.cf = 1'b1;
          r.st.cs = now;
          r.ev    = r.st.sf;
          r.st.sf = 1'b0;
          r.lvl   = level;
        end
      end else begin
        r.lvl = level;
      end
    end else begin
      r.st.cs = now;
    end
    return r;
  endfunction

  // Alarm pair always; warning pair only while the side is neither set nor cleared
  function automatic side_res_t side_eval(
    input limit_t                       alarm,
    input limit_t                       warn,
    input logic signed [VALUE_BITS-1:0] v,
    input logic [TIME_W-1:0]            now,
    input side_state_t                  st_in
  );
    side_res_t ra;
    side_res_t rw;
    ra = pair_check(alarm, v, now, LVL_ALARM, st_in);
    rw = pair_check(warn, v, now, LVL_WARN, ra.st);
    return (!ra.st.sf && !ra.st.cf) ? rw : ra;
  endfunction

endpackage

// ===== hdl/ctam_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ctam_cfg_regs
// Limit register file; one write transfer per cycle, always ready.
// ----------------------------------------------------------------------------
module ctam_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ctam_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ctam_pkg::LIMIT_W-1:0]    cfg_wdata,
  output ctam_pkg::cfg_t                  cfg_o
);
  import ctam_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  // register select
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ALARM_HIGH: cfg_nxt.alarm_hi = limit_t'(cfg_wdata);
        REG_WARN_HIGH:  cfg_nxt.warn_hi  = limit_t'(cfg_wdata);
        REG_ALARM_LOW:  cfg_nxt.alarm_lo = limit_t'(cfg_wdata);
        REG_WARN_LOW:   cfg_nxt.warn_lo  = limit_t'(cfg_wdata);
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== hdl/ctam_cell_store.sv =====
// ----------------------------------------------------------------------------
// ctam_cell_store
// Per-cell latch state memory with valid bits and write-to-read bypass.
// ----------------------------------------------------------------------------
module ctam_cell_store #(
  parameter  int NUM_CELLS = ctam_pkg::NUM_CELLS_DEF,
  localparam int AW        = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  ctam_pkg::cell_state_t wr_data,
  output ctam_pkg::cell_state_t rd_data
);
  import ctam_pkg::*;

  cell_state_t mem [NUM_CELLS];
  logic        vld_r [NUM_CELLS];

  cell_state_t rd_mem_r;
  cell_state_t byp_data_r;
  logic        rd_vld_r;
  logic        byp_hit_r;

  // memory array, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_mem_r   <= mem[rd_addr];
      byp_data_r <= wr_data;
    end
  end

  // valid bits: an entry never written reads as all zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CELLS; i++) begin
        vld_r[i] <= 1'b0;
      end
      rd_vld_r  <= 1'b0;
      byp_hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r  <= vld_r[rd_addr];
        byp_hit_r <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  // a write in the same cycle as the read wins
  always_comb begin
    if (byp_hit_r) begin
      rd_data = byp_data_r;
    end else if (rd_vld_r) begin
      rd_data = rd_mem_r;
    end else begin
      rd_data = '0;
    end
  end

endmodule

// ===== hdl/ctam_tracker.sv =====
// ----------------------------------------------------------------------------
// ctam_tracker
// Running maximum and minimum with their cells; cell 0 restarts tracking.
// ----------------------------------------------------------------------------
module ctam_tracker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                upd,
  input  logic [ctam_pkg::IDX_W-1:0]          cell_id,
  input  logic signed [ctam_pkg::VALUE_BITS-1:0] value,
  output ctam_pkg::trk_t                      trk_nxt_o
);
  import ctam_pkg::*;

  trk_t trk_r;
  trk_t trk_nxt;

  // updated extremes, including the sample at hand
  always_comb begin
    trk_nxt = trk_r;
    if (cell_id == '0) begin
      trk_nxt.peak_value   = value;
      trk_nxt.trough_value = value;
      trk_nxt.peak_cell    = '0;
      trk_nxt.trough_cell  = '0;
    end else begin
      if (value > trk_r.peak_value) begin
        trk_nxt.peak_value = value;
        trk_nxt.peak_cell  = cell_id;
      end
      if (value < trk_r.trough_value) begin
        trk_nxt.trough_value = value;
        trk_nxt.trough_cell  = cell_id;
      end
    end
  end

  assign trk_nxt_o = trk_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trk_r.peak_value   <= '0;
      trk_r.peak_cell    <= '0;
      trk_r.trough_value <= VALUE_BITS'(MIN_START);
      trk_r.trough_cell  <= '0;
    end else if (upd) begin
      trk_r <= trk_nxt;
    end
  end

endmodule

// ===== hdl/cell_threshold_alarm_monitor.sv =====
// ----------------------------------------------------------------------------
// cell_threshold_alarm_monitor
// Time-qualified hysteresis alarm per cell with running max/min tracking.
//
//   channel  direction  handshake                payload
//   in       input      in_valid / in_stall      ctam_pkg::in_item_t
//   out      output     out_valid / out_stall    ctam_pkg::out_item_t
//   cfg      input      cfg_valid / cfg_ready    cfg_index, cfg_wdata
//
// One sample per cycle sustained while out_stall is low; a sample is registered
// in stage 1 and then in the result register, from which its result transfers.
// Stage 1 reads the cell's latch state from the state memory
// (registered read, bypassed on back-to-back hits of one cell); the result
// register follows. Reset is synchronous; all latches read as clear at once.
// out_stall holds the result register and then stage 1; in_stall follows.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cell_threshold_alarm_monitor #(
  parameter int NUM_CELLS = ctam_pkg::NUM_CELLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ctam_pkg::in_item_t             in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ctam_pkg::out_item_t            out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ctam_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ctam_pkg::LIMIT_W-1:0]   cfg_wdata
);
  import ctam_pkg::*;

  localparam int AW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int IW = (AW > IDX_W) ? AW : IDX_W;

  cfg_t        cfg;
  cell_state_t rd_state;
  cell_state_t wr_state;
  trk_t        trk_view;
  side_res_t   hi_res;
  side_res_t   lo_res;

  // stage 1 and result registers
  logic        s1_vld_r;
  logic        s1_vld_nxt;
  in_item_t    s1_item_r;
  logic        s1_inrng_r;
  logic [AW-1:0] s1_addr_r;
  logic        out_vld_r;
  logic        out_vld_nxt;
  out_item_t   out_item_r;
  out_item_t   res;

  logic          in_xfer;
  logic          adv;
  logic          in_inrng;
  logic [IW-1:0] in_idx_ext;
  logic [AW-1:0] in_addr;

  // handshake: stage 1 moves when the result register is free or drains
  assign adv      = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !adv;
  assign in_xfer  = in_valid && !in_stall;

  assign in_idx_ext = IW'(in_item.cell_index);
  assign in_addr    = in_idx_ext[AW-1:0];
  assign in_inrng   = 32'(in_item.cell_index) < 32'(NUM_CELLS);

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  ctam_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  ctam_cell_store #(
    .NUM_CELLS (NUM_CELLS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_xfer && in_inrng),
    .rd_addr (in_addr),
    .wr_en   (adv && s1_inrng_r),
    .wr_addr (s1_addr_r),
    .wr_data (wr_state),
    .rd_data (rd_state)
  );

  ctam_tracker u_trk (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (adv),
    .cell_id   (s1_item_r.cell_index),
    .value     (s1_item_r.sample_value),
    .trk_nxt_o (trk_view)
  );

  // latch evaluation for both sides
  always_comb begin
    hi_res = side_eval(cfg.alarm_hi, cfg.warn_hi, s1_item_r.sample_value,
                       s1_item_r.now_seconds, rd_state.hi);
    lo_res = side_eval(cfg.alarm_lo, cfg.warn_lo, s1_item_r.sample_value,
                       s1_item_r.now_seconds, rd_state.lo);
    wr_state.hi = hi_res.st;
    wr_state.lo = lo_res.st;
  end

  // result assembly; latch fields read zero for cells beyond the store
  always_comb begin
    res.high_active  = s1_inrng_r && hi_res.st.sf;
    res.high_cleared = s1_inrng_r && hi_res.st.cf;
    res.high_event   = s1_inrng_r && hi_res.ev;
    res.high_level   = s1_inrng_r ? hi_res.lvl : LVL_NONE;
    res.low_active   = s1_inrng_r && lo_res.st.sf;
    res.low_cleared  = s1_inrng_r && lo_res.st.cf;
    res.low_event    = s1_inrng_r && lo_res.ev;
    res.low_level    = s1_inrng_r ? lo_res.lvl : LVL_NONE;
    res.peak_value   = trk_view.peak_value;
    res.peak_cell    = trk_view.peak_cell;
    res.trough_value = trk_view.trough_value;
    res.trough_cell  = trk_view.trough_cell;
  end

  // valid flags next state
  always_comb begin
    if (in_xfer) begin
      s1_vld_nxt = 1'b1;
    end else if (adv) begin
      s1_vld_nxt = 1'b0;
    end else begin
      s1_vld_nxt = s1_vld_r;
    end
    if (adv) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r  <= in_item;
      s1_inrng_r <= in_inrng;
      s1_addr_r  <= in_addr;
    end
    if (adv) begin
      out_item_r <= res;
    end
  end

  // a side is never set and cleared at once
  `ASSERT_CLK(a_latch_excl, clk, rst_n,
    out_vld_r |-> !(out_item_r.high_active && out_item_r.high_cleared) &&
    !(out_item_r.low_active && out_item_r.low_cleared))
  // an event always carries the level of the pair that acted
  `ASSERT_CLK(a_event_level, clk, rst_n,
    out_vld_r |-> (!out_item_r.high_event || (out_item_r.high_level != LVL_NONE)) &&
    (!out_item_r.low_event || (out_item_r.low_level != LVL_NONE)))
  // out-of-range cells leave the latch fields clear
  `ASSERT_CLK(a_oor_zero, clk, rst_n,
    (adv && !s1_inrng_r) |=> !out_item_r.high_active && !out_item_r.high_cleared &&
    !out_item_r.low_active && !out_item_r.low_cleared)
  // an advancing item always lands in the result register
  `ASSERT_CLK(a_adv_lands, clk, rst_n, adv |=> out_vld_r)

endmodule

// ===== bench/ctam_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctam_result_checker
// Watches the sample, report and limit channels of the cell alarm monitor.
// Keeps its own copy of the per-cell latches, the limit registers and the
// running extremes, and predicts one report per sample transfer. Each report
// transfer is compared field by field with the oldest predicted report.
// ----------------------------------------------------------------------------
module ctam_result_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  ctam_pkg::in_item_t             in_item,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  ctam_pkg::out_item_t            out_item,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ctam_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ctam_pkg::LIMIT_W-1:0]   cfg_wdata,
  output int                             fail_count,
  output int                             outstanding
);
  import ctam_pkg::*;

  localparam int CELLS = NUM_CELLS_DEF;

  // Set and clear latch of one side of one cell
  typedef struct packed {
    logic              on_flag;
    logic              off_flag;
    logic [TIME_W-1:0] on_since;
    logic [TIME_W-1:0] off_since;
  } latch_t;

  typedef struct packed {
    latch_t           lt;
    logic             ev;
    logic [LVL_W-1:0] lvl;
  } verdict_t;

  cfg_t             limits;
  latch_t           hi_latch [CELLS];
  latch_t           lo_latch [CELLS];
  int               peak;
  int               trough;
  logic [IDX_W-1:0] peak_at;
  logic [IDX_W-1:0] trough_at;
  out_item_t        awaited_reports [$];
  int               fails = 0;

  // One set/clear pair against one limit register
  function automatic verdict_t apply_limit(limit_t lim, int v, logic [TIME_W-1:0] now,
                                           logic [LVL_W-1:0] level, latch_t lt);
    verdict_t          r;
    int                on_thr;
    int                off_thr;
    logic              on_hit;
    logic              off_hit;
    logic [TIME_W-1:0] hold;
    logic [TIME_W-1:0] elapsed;
    on_thr  = $signed(lim.set);
    off_thr = $signed(lim.clr);
    hold    = lim.dur;
    case (lim.cmp)
      CMP_GT: begin
        on_hit  = v > on_thr;
        off_hit = v < off_thr;
      end
      CMP_GE: begin
        on_hit  = v >= on_thr;
        off_hit = v <= off_thr;
      end
      CMP_LT: begin
        on_hit  = v < on_thr;
        off_hit = v > off_thr;
      end
      default: begin
        on_hit  = v <= on_thr;
        off_hit = v >= off_thr;
      end
    endcase
    r.lt  = lt;
    r.ev  = 1'b0;
    r.lvl = LVL_NONE;
    // set condition; elapsed time wraps mod 2^32
    elapsed = now - r.lt.on_since;
    if (!on_hit) begin
      r.lt.on_since = now;
    end else if (r.lt.on_flag) begin
      r.lvl = level;
    end else if (elapsed > hold) begin
      r.lt.on_flag  = 1'b1;
      r.lt.off_flag = 1'b0;
      r.lt.on_since = now;
      r.ev          = 1'b1;
      r.lvl         = level;
    end
    // clear condition sees the set latch as just updated
    elapsed = now - r.lt.off_since;
    if (!off_hit) begin
      r.lt.off_since = now;
    end else if (r.lt.off_flag) begin
      r.lvl = level;
    end else if (elapsed > hold) begin
      r.lt.off_flag  = 1'b1;
      r.lt.off_since = now;
      r.ev           = r.lt.on_flag;
      r.lt.on_flag   = 1'b0;
      r.lvl          = level;
    end
    return r;
  endfunction

  // Warning pair only counts while the alarm pair left the side undecided
  function automatic verdict_t judge_side(limit_t alarm, limit_t warn, int v,
                                          logic [TIME_W-1:0] now, latch_t lt);
    verdict_t by_alarm;
    by_alarm = apply_limit(alarm, v, now, LVL_ALARM, lt);
    if (by_alarm.lt.on_flag || by_alarm.lt.off_flag) return by_alarm;
    return apply_limit(warn, v, now, LVL_WARN, by_alarm.lt);
  endfunction

  task automatic evaluate_sample(in_item_t s);
    out_item_t rep;
    verdict_t  hv;
    verdict_t  lv;
    int        v;
    v = $signed(s.sample_value);
    // running extremes, index 0 restarts them
    if (s.cell_index == 0) begin
      peak      = v;
      trough    = v;
      peak_at   = '0;
      trough_at = '0;
    end else begin
      if (v > peak) begin
        peak    = v;
        peak_at = s.cell_index;
      end
      if (v < trough) begin
        trough    = v;
        trough_at = s.cell_index;
      end
    end
    rep = '0;
    if (s.cell_index < CELLS) begin
      hv = judge_side(limits.alarm_hi, limits.warn_hi, v, s.now_seconds,
                      hi_latch[s.cell_index]);
      lv = judge_side(limits.alarm_lo, limits.warn_lo, v, s.now_seconds,
                      lo_latch[s.cell_index]);
      hi_latch[s.cell_index] = hv.lt;
      lo_latch[s.cell_index] = lv.lt;
      rep.high_active  = hv.lt.on_flag;
      rep.high_cleared = hv.lt.off_flag;
      rep.high_event   = hv.ev;
      rep.high_level   = hv.lvl;
      rep.low_active   = lv.lt.on_flag;
      rep.low_cleared  = lv.lt.off_flag;
      rep.low_event    = lv.ev;
      rep.low_level    = lv.lvl;
    end
    rep.peak_value   = VALUE_BITS'(peak);
    rep.peak_cell    = peak_at;
    rep.trough_value = VALUE_BITS'(trough);
    rep.trough_cell  = trough_at;
    awaited_reports.push_back(rep);
  endtask

  task automatic match_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  task automatic match_report(out_item_t got);
    out_item_t want;
    if (awaited_reports.size() == 0) begin
      $error("report transfer with no sample awaiting it");
      fails++;
    end else begin
      want = awaited_reports.pop_front();
      match_field("high_active", want.high_active, got.high_active);
      match_field("high_cleared", want.high_cleared, got.high_cleared);
      match_field("high_event", want.high_event, got.high_event);
      match_field("high_level", want.high_level, got.high_level);
      match_field("low_active", want.low_active, got.low_active);
      match_field("low_cleared", want.low_cleared, got.low_cleared);
      match_field("low_event", want.low_event, got.low_event);
      match_field("low_level", want.low_level, got.low_level);
      match_field("peak_value", $signed(want.peak_value), $signed(got.peak_value));
      match_field("peak_cell", want.peak_cell, got.peak_cell);
      match_field("trough_value", $signed(want.trough_value), $signed(got.trough_value));
      match_field("trough_cell", want.trough_cell, got.trough_cell);
    end
  endtask

  // Channel monitor: limit writes, then reports, then new samples
  always @(posedge clk) begin
    if (!rst_n) begin
      limits = '0;
      for (int c = 0; c < CELLS; c++) begin
        hi_latch[c] = '0;
        lo_latch[c] = '0;
      end
      peak      = 0;
      trough    = MIN_START;
      peak_at   = '0;
      trough_at = '0;
      awaited_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ALARM_HIGH: limits.alarm_hi = cfg_wdata;
          REG_WARN_HIGH:  limits.warn_hi  = cfg_wdata;
          REG_ALARM_LOW:  limits.alarm_lo = cfg_wdata;
          REG_WARN_LOW:   limits.warn_lo  = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) match_report(out_item);
      if (in_valid && !in_stall) evaluate_sample(in_item);
    end
    fail_count  <= fails;
    outstanding <= awaited_reports.size();
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the cell alarm monitor: a directed run over reset limits,
// hand-picked limits and extreme limits, then randomized limit settings with
// samples clustered around the thresholds. Sender and receiver idle at random
// in the first two of three phases; the checker beside the block does all comparison.
// ----------------------------------------------------------------------------
module tb;
  import ctam_pkg::*;

  localparam int WATCHDOG_LIMIT      = 4000;
  localparam int SAMPLES_PER_SETTING = 72;
  localparam int SETTINGS_PER_PHASE  = 2;
  localparam int WINDOW_CELLS        = 5;
  localparam int DUR_MAX             = (1 << DUR_W) - 1;

  localparam logic signed [VALUE_BITS-1:0] V_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] V_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LIMIT_W-1:0]   cfg_wdata = '0;

  int                   fail_count;
  int                   outstanding;
  int                   send_idle    = 0;
  int                   recv_idle    = 0;
  int                   quiet_cycles = 0;
  logic [TIME_W-1:0]    sim_seconds  = '0;
  cfg_t                 cur_limits   = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  cell_threshold_alarm_monitor uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ctam_result_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  // Watchdog: ends the run once nothing has transferred for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic limit_t mk_limit(int st, int cl, cmp_t m, int d);
    limit_t l;
    l.set = st[THR_W-1:0];
    l.clr = cl[THR_W-1:0];
    l.cmp = m;
    l.dur = d[DUR_W-1:0];
    return l;
  endfunction

  // Hysteresis band around a random base; sometimes anything at all
  function automatic limit_t random_limit(bit upper);
    limit_t l;
    int     base;
    int     gap;
    int     roll;
    base = int'($urandom_range(0, 6000)) - 1000;
    gap  = $urandom_range(0, 300);
    roll = $urandom_range(99);
    if (roll < 15)
      l = mk_limit($urandom(), $urandom(),
                   cmp_t'($urandom_range(int'(CMP_GT), int'(CMP_LE))), 0);
    else if (upper)
      l = mk_limit(base, base - gap, $urandom_range(1) ? CMP_GT : CMP_GE, 0);
    else
      l = mk_limit(base, base + gap, $urandom_range(1) ? CMP_LT : CMP_LE, 0);
    if ($urandom_range(9) == 0) l.set = $urandom_range(1) ? V_MAX : V_MIN;
    if ($urandom_range(9) == 0) l.clr = $urandom_range(1) ? V_MAX : V_MIN;
    roll = $urandom_range(99);
    if (roll < 10)      l.dur = '0;
    else if (roll < 15) l.dur = '1;
    else if (roll < 70) l.dur = $urandom_range(1, 4);
    else                l.dur = $urandom_range(5, 15);
    return l;
  endfunction

  // Mostly values just around one of the active thresholds
  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    int marks [8];
    int roll;
    marks[0] = $signed(cur_limits.alarm_hi.set);
    marks[1] = $signed(cur_limits.alarm_hi.clr);
    marks[2] = $signed(cur_limits.warn_hi.set);
    marks[3] = $signed(cur_limits.warn_hi.clr);
    marks[4] = $signed(cur_limits.alarm_lo.set);
    marks[5] = $signed(cur_limits.alarm_lo.clr);
    marks[6] = $signed(cur_limits.warn_lo.set);
    marks[7] = $signed(cur_limits.warn_lo.clr);
    roll = $urandom_range(99);
    if (roll < 70) return VALUE_BITS'(marks[$urandom_range(7)] + int'($urandom_range(0, 8)) - 4);
    if (roll < 85) return VALUE_BITS'($urandom());
    if (roll < 90) return $urandom_range(1) ? V_MAX : V_MIN;
    return VALUE_BITS'(int'($urandom_range(0, 8000)) - 2000);
  endfunction

  // One sample transfer; valid stays high into the next sample unless idling
  task automatic push_sample(logic [IDX_W-1:0] idx, logic signed [VALUE_BITS-1:0] value,
                             logic [TIME_W-1:0] stamp);
    in_item_t s;
    s.cell_index   = idx;
    s.sample_value = value;
    s.now_seconds  = stamp;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= s;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold off until every report is back, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic offer_limit(cfg_reg_t r, limit_t w);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= w;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_limits(cfg_t c);
    offer_limit(REG_ALARM_HIGH, c.alarm_hi);
    offer_limit(REG_WARN_HIGH, c.warn_hi);
    offer_limit(REG_ALARM_LOW, c.alarm_lo);
    offer_limit(REG_WARN_LOW, c.warn_lo);
    cfg_valid  <= 1'b0;
    cur_limits = c;
  endtask

  initial begin
    cfg_t lims;
    int   roll;
    int   window;
    int   idx;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset limits: all zero thresholds, GT, no hold time
    send_idle = 23;
    recv_idle = 53;
    push_sample(0, 0, 0);
    push_sample(31, V_MAX, 1);
    push_sample(5, V_MIN, 2);
    push_sample(5, 0, 2);
    drain();

    // Hand-picked limits: one comparator per register, long alarm hold
    lims.alarm_hi = mk_limit(4200, 4100, CMP_GT, 20);
    lims.warn_hi  = mk_limit(4000, 3900, CMP_GE, 0);
    lims.alarm_lo = mk_limit(2800, 3000, CMP_LT, 20);
    lims.warn_lo  = mk_limit(3000, 3100, CMP_LE, 0);
    program_limits(lims);
    // warning high, then alarm high held, then drop to clear
    push_sample(3, 4050, 10);
    push_sample(3, 4300, 12);
    push_sample(3, 4300, 33);
    push_sample(3, 4150, 34);
    push_sample(3, 3850, 35);
    push_sample(3, 3850, 60);
    // low side
    push_sample(7, 2900, 10);
    push_sample(7, 2700, 11);
    push_sample(7, 2700, 40);
    push_sample(7, 3200, 70);
    // threshold equality for GE and LE
    push_sample(9, 4000, 20);
    push_sample(9, 3000, 20);
    // time wrap, then time running backwards
    push_sample(3, 4300, '1);
    push_sample(3, 4300, 5);
    push_sample(7, 2700, 3);
    // tracking restart and new extremes
    push_sample(0, 1234, 100);
    push_sample(12, -5, 101);
    push_sample(30, 6000, 102);
    drain();

    // Extreme thresholds and hold times
    lims.alarm_hi = mk_limit(V_MAX, V_MIN, CMP_LE, DUR_MAX);
    lims.warn_hi  = mk_limit(V_MIN, V_MAX, CMP_GE, 0);
    lims.alarm_lo = mk_limit(V_MIN, V_MAX, CMP_LT, 0);
    lims.warn_lo  = mk_limit(V_MAX, V_MIN, CMP_GT, DUR_MAX);
    program_limits(lims);
    push_sample(20, V_MAX, 200);
    push_sample(21, V_MIN, 201);
    push_sample(22, 0, 202);

    // Random limit settings, each on a fresh window of cells
    sim_seconds = 300;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 23 : (ph == 1) ? 53 : 0;
      recv_idle = (ph == 0) ? 53 : (ph == 1) ? 23 : 0;
      for (int k = 0; k < SETTINGS_PER_PHASE; k++) begin
        window = 1 + WINDOW_CELLS * (ph * SETTINGS_PER_PHASE + k);
        drain();
        lims.alarm_hi = random_limit(1'b1);
        lims.warn_hi  = random_limit(1'b1);
        lims.alarm_lo = random_limit(1'b0);
        lims.warn_lo  = random_limit(1'b0);
        program_limits(lims);
        repeat (SAMPLES_PER_SETTING) begin
          roll = $urandom_range(99);
          if (roll < 2)       sim_seconds = $urandom();
          else if (roll < 5)  sim_seconds = sim_seconds - $urandom_range(1, 20);
          else if (roll < 45) sim_seconds = sim_seconds + 1;
          roll = $urandom_range(99);
          if (roll < 5)       idx = 0;
          else if (roll < 85) idx = window + $urandom_range(0, WINDOW_CELLS - 1);
          else                idx = $urandom_range(0, (1 << IDX_W) - 1);
          push_sample(idx, pick_value(), sim_seconds);
        end
      end
    end

    drain();
    if (fail_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
